// ===== rtl/ecsm_pkg.sv =====
// Shared types and constants for the elliptic curve scalar multiplier.
package ecsm_pkg;

  localparam int FIELD_BITS  = 16;
  localparam int SCALAR_BITS = 32;
  localparam int WIDE_BITS   = FIELD_BITS + 1;
  localparam int CNT_BITS    = $clog2(SCALAR_BITS);
  localparam int MUL_CNT_BITS = $clog2(FIELD_BITS + 1);

  localparam logic [FIELD_BITS-1:0] MODULUS_RESET = FIELD_BITS'(97);
  localparam logic [FIELD_BITS-1:0] CURVE_A_RESET = FIELD_BITS'(2);

  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_CURVE_A = 1'b1;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic                  start;
    alu_op_t               op;
    logic [FIELD_BITS-1:0] a;
    logic [FIELD_BITS-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                  done;
    logic [FIELD_BITS-1:0] result;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RX,
    S_RY,
    S_RA,
    S_SCAN,
    S_LOOP,
    S_DCHK,
    S_D1,
    S_D2,
    S_D3,
    S_D4,
    S_D5,
    S_ACHK,
    S_A1,
    S_A2,
    S_INV0,
    S_INVL,
    S_INVM,
    S_INVS,
    S_F1,
    S_F2,
    S_F3,
    S_F4,
    S_F5,
    S_F6,
    S_F7,
    S_NEXT,
    S_OUT
  } state_t;

endpackage

// ===== rtl/ecsm_alu.sv =====
// Shared modular arithmetic unit: bit-serial multiply; add and subtract registered from the request.
module ecsm_alu
  import ecsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [FIELD_BITS-1:0] modulus,
  input  alu_req_t              req,
  output alu_rsp_t              rsp
);

  logic                    busy;
  logic [MUL_CNT_BITS-1:0] cnt;
  logic [FIELD_BITS-1:0]   acc;
  logic [FIELD_BITS-1:0]   mcand;
  logic [FIELD_BITS-1:0]   mplier;
  logic                    done;
  logic [FIELD_BITS-1:0]   result;

  logic [WIDE_BITS-1:0] m_w;
  logic [WIDE_BITS-1:0] dbl;
  logic [WIDE_BITS-1:0] dbl_r;
  logic [WIDE_BITS-1:0] sum;
  logic [WIDE_BITS-1:0] sum_r;
  logic [WIDE_BITS-1:0] add_s;
  logic [WIDE_BITS-1:0] add_r;
  logic [WIDE_BITS-1:0] sub_r;

  always_comb begin
    m_w   = {1'b0, modulus};
    dbl   = {acc, 1'b0};
    dbl_r = (dbl >= m_w) ? dbl - m_w : dbl;
    sum   = mplier[FIELD_BITS-1] ? dbl_r + {1'b0, mcand} : dbl_r;
    sum_r = (sum >= m_w) ? sum - m_w : sum;
    add_s = {1'b0, req.a} + {1'b0, req.b};
    add_r = (add_s >= m_w) ? add_s - m_w : add_s;
    sub_r = (req.a >= req.b) ? {1'b0, req.a} - {1'b0, req.b}
                             : {1'b0, req.a} + m_w - {1'b0, req.b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= (busy && cnt == MUL_CNT_BITS'(1)) ||
              (!busy && req.start && req.op != ALU_MUL);
      if (busy) begin
        acc    <= sum_r[FIELD_BITS-1:0];
        mplier <= {mplier[FIELD_BITS-2:0], 1'b0};
        cnt    <= cnt - 1'b1;
        if (cnt == MUL_CNT_BITS'(1)) begin
          busy   <= 1'b0;
          result <= sum_r[FIELD_BITS-1:0];
        end
      end else if (req.start) begin
        case (req.op)
          ALU_MUL: begin
            busy   <= 1'b1;
            acc    <= '0;
            mcand  <= req.a;
            mplier <= req.b;
            cnt    <= MUL_CNT_BITS'(FIELD_BITS);
          end
          ALU_ADD: begin
            result <= add_r[FIELD_BITS-1:0];
          end
          ALU_SUB: begin
            result <= sub_r[FIELD_BITS-1:0];
          end
          default: begin
            result <= '0;
          end
        endcase
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("alu start while busy");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done || $past(req.start)) else $error("alu done repeated");
  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0) else $error("alu busy with zero count");
`endif

endmodule

// ===== rtl/ec_scalar_multiply.sv =====
// Top level: elliptic curve k*P by left-to-right double-and-add over GF(p).
//
//  channel | signals                                       | dir
//  in      | in_valid in_stall point_x point_y             | in
//          | point_is_infinity scalar                      |
//  out     | out_valid out_stall result_x result_y         | out
//          | result_is_infinity                            |
//  cfg     | psel penable pwrite paddr pwdata prdata pready| in/out
//
// One word at a time; in_stall is high while a word is in work.
// A field multiply is bit-serial in the shared unit; an inverse z^(p-2)
// takes up to 2*FIELD_BITS multiplies. A zero scalar, an infinity input
// or a modulus below 2 goes straight to the output.
// Reset: synchronous on rst, registers go to p=97, a=2.
// A result held by out_stall blocks the next result but not the next input.
module ec_scalar_multiply
  import ecsm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FIELD_BITS-1:0]  point_x,
  input  logic [FIELD_BITS-1:0]  point_y,
  input  logic                   point_is_infinity,
  input  logic [SCALAR_BITS-1:0] scalar,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [FIELD_BITS-1:0]  result_x,
  output logic [FIELD_BITS-1:0]  result_y,
  output logic                   result_is_infinity,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  state_t state;
  state_t state_next;

  logic [FIELD_BITS-1:0]  modulus;
  logic [FIELD_BITS-1:0]  curve_a;
  logic [FIELD_BITS-1:0]  ar;
  logic [FIELD_BITS-1:0]  bx;
  logic [FIELD_BITS-1:0]  by;
  logic [FIELD_BITS-1:0]  ax;
  logic [FIELD_BITS-1:0]  ay;
  logic                   ainf;
  logic [FIELD_BITS-1:0]  t0;
  logic [FIELD_BITS-1:0]  t1;
  logic [FIELD_BITS-1:0]  s;
  logic [FIELD_BITS-1:0]  ir;
  logic [FIELD_BITS-1:0]  ib;
  logic [FIELD_BITS-1:0]  e;
  logic [SCALAR_BITS-1:0] kreg;
  logic [CNT_BITS-1:0]    cnt;
  logic                   bitreg;
  logic                   phase_add;
  logic                   dbl_mode;
  logic                   issued;
  logic                   is_op;
  logic                   accept;
  logic                   trivial;
  logic                   out_load;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  ecsm_alu u_alu (
    .clk     (clk),
    .rst     (rst),
    .modulus (modulus),
    .req     (alu_req),
    .rsp     (alu_rsp)
  );

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_CURVE_A) ? {16'(0), curve_a} : {16'(0), modulus};
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign trivial  = (modulus < FIELD_BITS'(2)) || (scalar == '0) || point_is_infinity;
  assign out_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
      curve_a <= CURVE_A_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_MODULUS) modulus <= pwdata[FIELD_BITS-1:0];
      else curve_a <= pwdata[FIELD_BITS-1:0];
    end
  end

  // Sequencer: next state and shared unit request.
  always_comb begin
    state_next  = state;
    is_op       = 1'b0;
    alu_req.op  = ALU_MUL;
    alu_req.a   = '0;
    alu_req.b   = '0;
    case (state)
      S_IDLE: if (accept) state_next = trivial ? S_OUT : S_RX;
      S_RX:   begin is_op = 1'b1; alu_req.a = FIELD_BITS'(1); alu_req.b = bx; end
      S_RY:   begin is_op = 1'b1; alu_req.a = FIELD_BITS'(1); alu_req.b = by; end
      S_RA:   begin is_op = 1'b1; alu_req.a = FIELD_BITS'(1); alu_req.b = ar; end
      S_SCAN: if (kreg[SCALAR_BITS-1]) state_next = S_LOOP;
      S_LOOP: state_next = (cnt == '0) ? S_OUT : S_DCHK;
      S_DCHK: state_next = (ainf || ay == '0) ? S_NEXT : S_D1;
      S_D1:   begin is_op = 1'b1; alu_req.a = ax; alu_req.b = ax; end
      S_D2:   begin is_op = 1'b1; alu_req.op = ALU_ADD; alu_req.a = t0; alu_req.b = t0; end
      S_D3:   begin is_op = 1'b1; alu_req.op = ALU_ADD; alu_req.a = t1; alu_req.b = t0; end
      S_D4:   begin is_op = 1'b1; alu_req.op = ALU_ADD; alu_req.a = t0; alu_req.b = ar; end
      S_D5:   begin is_op = 1'b1; alu_req.op = ALU_ADD; alu_req.a = ay; alu_req.b = ay; end
      S_ACHK: begin
        if (ainf) state_next = S_NEXT;
        else if (ax == bx) state_next = (ay == by) ? S_DCHK : S_NEXT;
        else state_next = S_A1;
      end
      S_A1:   begin is_op = 1'b1; alu_req.op = ALU_SUB; alu_req.a = ay; alu_req.b = by; end
      S_A2:   begin is_op = 1'b1; alu_req.op = ALU_SUB; alu_req.a = ax; alu_req.b = bx; end
      S_INV0: state_next = S_INVL;
      S_INVL: begin
        if (e == '0) state_next = S_F1;
        else state_next = e[0] ? S_INVM : S_INVS;
      end
      S_INVM: begin is_op = 1'b1; alu_req.a = ir; alu_req.b = ib; end
      S_INVS: begin is_op = 1'b1; alu_req.a = ib; alu_req.b = ib; end
      S_F1:   begin is_op = 1'b1; alu_req.a = t0; alu_req.b = t1; end
      S_F2:   begin is_op = 1'b1; alu_req.a = s; alu_req.b = s; end
      S_F3:   begin is_op = 1'b1; alu_req.op = ALU_SUB; alu_req.a = t0; alu_req.b = ax; end
      S_F4:   begin
        is_op = 1'b1; alu_req.op = ALU_SUB; alu_req.a = t0;
        alu_req.b = dbl_mode ? ax : bx;
      end
      S_F5:   begin is_op = 1'b1; alu_req.op = ALU_SUB; alu_req.a = ax; alu_req.b = t0; end
      S_F6:   begin is_op = 1'b1; alu_req.a = s; alu_req.b = t1; end
      S_F7:   begin is_op = 1'b1; alu_req.op = ALU_SUB; alu_req.a = t1; alu_req.b = ay; end
      S_NEXT: state_next = (!phase_add && bitreg) ? S_ACHK : S_LOOP;
      S_OUT:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (is_op && alu_rsp.done) begin
      case (state)
        S_RX:    state_next = S_RY;
        S_RY:    state_next = S_RA;
        S_RA:    state_next = S_SCAN;
        S_D1:    state_next = S_D2;
        S_D2:    state_next = S_D3;
        S_D3:    state_next = S_D4;
        S_D4:    state_next = S_D5;
        S_D5:    state_next = S_INV0;
        S_A1:    state_next = S_A2;
        S_A2:    state_next = S_INV0;
        S_INVM:  state_next = S_INVS;
        S_INVS:  state_next = S_INVL;
        S_F1:    state_next = S_F2;
        S_F2:    state_next = S_F3;
        S_F3:    state_next = S_F4;
        S_F4:    state_next = S_F5;
        S_F5:    state_next = S_F6;
        S_F6:    state_next = S_F7;
        S_F7:    state_next = S_NEXT;
        default: state_next = S_IDLE;
      endcase
    end
    alu_req.start = is_op && !issued;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= is_op && !alu_rsp.done;
      if (state == S_OUT && out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (accept) begin
        bx   <= point_x;
        by   <= point_y;
        ar   <= curve_a;
        kreg <= scalar;
        cnt  <= CNT_BITS'(SCALAR_BITS - 1);
        ainf <= trivial;
      end
      S_SCAN: begin
        kreg <= {kreg[SCALAR_BITS-2:0], 1'b0};
        if (kreg[SCALAR_BITS-1]) begin
          ax   <= bx;
          ay   <= by;
          ainf <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      S_LOOP: if (cnt != '0) begin
        bitreg    <= kreg[SCALAR_BITS-1];
        kreg      <= {kreg[SCALAR_BITS-2:0], 1'b0};
        cnt       <= cnt - 1'b1;
        phase_add <= 1'b0;
        dbl_mode  <= 1'b1;
      end
      S_DCHK: if (ainf || ay == '0) ainf <= 1'b1;
      S_ACHK: begin
        if (ainf) begin
          ax   <= bx;
          ay   <= by;
          ainf <= 1'b0;
        end else if (ax == bx) begin
          if (ay == by) dbl_mode <= 1'b1;
          else ainf <= 1'b1;
        end else begin
          dbl_mode <= 1'b0;
        end
      end
      S_INV0: begin
        e  <= modulus - FIELD_BITS'(2);
        ir <= FIELD_BITS'(1);
        ib <= t1;
      end
      S_INVL: if (e == '0) t1 <= ir;
      S_NEXT: if (!phase_add && bitreg) phase_add <= 1'b1;
      S_OUT: if (out_load) begin
        result_x           <= ainf ? '0 : ax;
        result_y           <= ainf ? '0 : ay;
        result_is_infinity <= ainf;
      end
      default: ;
    endcase
    if (is_op && alu_rsp.done) begin
      case (state)
        S_RX:    bx <= alu_rsp.result;
        S_RY:    by <= alu_rsp.result;
        S_RA:    ar <= alu_rsp.result;
        S_D1, S_D3, S_D4, S_A1, S_F2, S_F3, S_F4: t0 <= alu_rsp.result;
        S_D2, S_D5, S_A2, S_F5, S_F6: t1 <= alu_rsp.result;
        S_INVM:  ir <= alu_rsp.result;
        S_INVS: begin
          ib <= alu_rsp.result;
          e  <= {1'b0, e[FIELD_BITS-1:1]};
        end
        S_F1:    s <= alu_rsp.result;
        S_F7: begin
          ay   <= alu_rsp.result;
          ax   <= t0;
          ainf <= 1'b0;
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_x) && $stable(result_y))
    else $error("held result changed");
  a_inf_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_is_infinity |-> result_x == '0 && result_y == '0)
    else $error("infinity result with nonzero coordinates");
  a_no_alu_idle: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |-> state != S_IDLE && state != S_OUT)
    else $error("arithmetic started outside a word");
`endif

endmodule
